[design/chtab_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtab_pkg
// Shared sizes, codes and controller/datapath handshake types of the
// chained hash table.
// ----------------------------------------------------------------------------
package chtab_pkg;

  // Table geometry
  localparam int MAX_BUCKETS  = 64;
  localparam int BUCKET_DEPTH = 16;

  // Field widths
  localparam int KEY_W    = 31;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int BUCKET_W = $clog2(MAX_BUCKETS);
  localparam int POS_W    = $clog2(BUCKET_DEPTH);
  localparam int FILL_W   = POS_W + 1;
  localparam int BCOUNT_W = 7;
  localparam int SLOT_AW  = BUCKET_W + POS_W;

  // Remainder loop: one key bit per cycle
  localparam int DIV_STEPS = KEY_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam logic [BCOUNT_W-1:0] BCOUNT_RESET = BCOUNT_W'(MAX_BUCKETS);
  localparam logic [BCOUNT_W-1:0] BCOUNT_MAX   = BCOUNT_W'(MAX_BUCKETS);
  localparam logic [FILL_W-1:0]   FILL_FULL    = FILL_W'(BUCKET_DEPTH);

  // Commands
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DEL_FAIL  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;

  // Slot read offset relative to the walk index
  typedef enum logic [1:0] {
    OFF_DEC,
    OFF_SAME,
    OFF_INC
  } rd_off_t;

  // Walk index update
  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  // Controller to datapath
  typedef struct packed {
    logic                load;
    logic                div_step;
    logic                fill_rd;
    logic                fill_cap;
    logic                fill_wr;
    logic                fill_inc;
    logic                slot_rd;
    rd_off_t             rd_off;
    logic                slot_wr;
    logic                wr_key;
    idx_op_t             idx_op;
    logic                out_load;
    logic [STATUS_W-1:0] status;
  } chtab_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             fill_full;
    logic             fill_zero;
    logic             idx_one;
    logic             idx_last;
    logic             idx_last2;
    logic             match;
    logic             out_busy;
  } chtab_sts_t;

endpackage

[design/chtab_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtab channel interfaces
// Valid/ready channels for commands, results and the bucket count register.
// ----------------------------------------------------------------------------
interface chtab_in_if;
  import chtab_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [KEY_W-1:0] key;
  modport source (output valid, output command, output key, input ready);
  modport sink   (input valid, input command, input key, output ready);
endinterface

interface chtab_out_if;
  import chtab_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BUCKET_W-1:0] bucket;
  logic [POS_W-1:0]    position;
  modport source (output valid, output status, output bucket, output position, input ready);
  modport sink   (input valid, input status, input bucket, input position, output ready);
endinterface

interface chtab_cfg_if;
  import chtab_pkg::*;
  logic                valid;
  logic                ready;
  logic [BCOUNT_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/chtab_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtab_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module chtab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write, then registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/chtab_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtab_datapath
// Remainder unit, bucket fill store, slot store, walk index and result
// register of the chained hash table.
// ----------------------------------------------------------------------------
module chtab_datapath
  import chtab_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [BCOUNT_W-1:0] cfg_data,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [KEY_W-1:0]    in_key,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [BUCKET_W-1:0] out_bucket,
  output logic [POS_W-1:0]    out_position,
  input  chtab_ctl_t          ctl,
  output chtab_sts_t          sts
);

  logic [BCOUNT_W-1:0]    bcount_r;
  logic [BCOUNT_W-1:0]    act_n;
  logic [CMD_W-1:0]       cmd_r;
  logic [KEY_W-1:0]       key_r;
  logic [KEY_W-1:0]       div_r;
  logic [BUCKET_W-1:0]    rem_r;
  logic [BUCKET_W:0]      rem_sh;
  logic [BUCKET_W-1:0]    rem_nxt;
  logic [FILL_W-1:0]      fill_r;
  logic [FILL_W-1:0]      fill_val;
  logic [FILL_W-1:0]      fill_rdata;
  logic [FILL_W-1:0]      fill_wdata;
  logic [MAX_BUCKETS-1:0] fvalid_r;
  logic [FILL_W-1:0]      idx_r;
  logic [FILL_W-1:0]      idx_inc;
  logic [FILL_W-1:0]      idx_dec;
  logic [FILL_W-1:0]      rd_idx;
  logic [SLOT_AW-1:0]     slot_raddr;
  logic [SLOT_AW-1:0]     slot_waddr;
  logic [KEY_W-1:0]       slot_rdata;
  logic [KEY_W-1:0]       slot_wdata;
  logic                   out_valid_r;
  logic [STATUS_W-1:0]    out_status_r;
  logic [BUCKET_W-1:0]    out_bucket_r;
  logic [POS_W-1:0]       out_position_r;

  // Clamp the bucket count into 1..MAX_BUCKETS
  always_comb begin
    if (bcount_r == '0) begin
      act_n = BCOUNT_W'(1);
    end else if (bcount_r > BCOUNT_MAX) begin
      act_n = BCOUNT_MAX;
    end else begin
      act_n = bcount_r;
    end
  end

  // One restoring remainder step: bring in the next key bit, subtract if it fits
  always_comb begin
    rem_sh = {rem_r, div_r[KEY_W-1]};
    if (rem_sh >= act_n) begin
      rem_nxt = BUCKET_W'(rem_sh - act_n);
    end else begin
      rem_nxt = rem_sh[BUCKET_W-1:0];
    end
  end

  // Walk index arithmetic and slot addresses
  assign idx_inc = idx_r + FILL_W'(1);
  assign idx_dec = idx_r - FILL_W'(1);

  always_comb begin
    case (ctl.rd_off)
      OFF_DEC: rd_idx = idx_dec;
      OFF_INC: rd_idx = idx_inc;
      default: rd_idx = idx_r;
    endcase
  end

  assign slot_raddr = {rem_r, rd_idx[POS_W-1:0]};
  assign slot_waddr = {rem_r, idx_r[POS_W-1:0]};
  assign slot_wdata = ctl.wr_key ? key_r : slot_rdata;

  // Fill count: an unwritten bucket reads as empty
  assign fill_val   = fvalid_r[rem_r] ? fill_rdata : '0;
  assign fill_wdata = ctl.fill_inc ? (fill_r + FILL_W'(1)) : (fill_r - FILL_W'(1));

  chtab_ram #(
    .WIDTH (FILL_W),
    .DEPTH (MAX_BUCKETS)
  ) u_fill_ram (
    .clk     (clk),
    .wr_en   (ctl.fill_wr),
    .wr_addr (rem_r),
    .wr_data (fill_wdata),
    .rd_en   (ctl.fill_rd),
    .rd_addr (rem_r),
    .rd_data (fill_rdata)
  );

  chtab_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_BUCKETS * BUCKET_DEPTH)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ctl.slot_wr),
    .wr_addr (slot_waddr),
    .wr_data (slot_wdata),
    .rd_en   (ctl.slot_rd),
    .rd_addr (slot_raddr),
    .rd_data (slot_rdata)
  );

  // Control state: bucket count, fill valid bits, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcount_r    <= BCOUNT_RESET;
      fvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        bcount_r <= cfg_data;
      end
      if (ctl.fill_wr) begin
        fvalid_r[rem_r] <= 1'b1;
      end
      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_command;
      key_r <= in_key;
      div_r <= in_key;
      rem_r <= '0;
    end else if (ctl.div_step) begin
      div_r <= {div_r[KEY_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
    if (ctl.fill_cap) begin
      fill_r <= fill_val;
      idx_r  <= (cmd_r == CMD_INSERT) ? fill_val : '0;
    end else begin
      case (ctl.idx_op)
        IDX_INC: idx_r <= idx_inc;
        IDX_DEC: idx_r <= idx_dec;
        default: idx_r <= idx_r;
      endcase
    end
    if (ctl.out_load) begin
      out_status_r   <= ctl.status;
      out_bucket_r   <= rem_r;
      out_position_r <= (ctl.status == ST_FOUND) ? idx_r[POS_W-1:0] : '0;
    end
  end

  // Status back to the controller
  assign sts.cmd       = cmd_r;
  assign sts.fill_full = (fill_r == FILL_FULL);
  assign sts.fill_zero = (fill_r == '0);
  assign sts.idx_one   = (idx_r == FILL_W'(1));
  assign sts.idx_last  = (idx_inc == fill_r);
  assign sts.idx_last2 = ((idx_r + FILL_W'(2)) == fill_r);
  assign sts.match     = (slot_rdata == key_r);
  assign sts.out_busy  = out_valid_r & ~out_ready;

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_bucket   = out_bucket_r;
  assign out_position = out_position_r;

endmodule

[design/chtab_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtab_ctrl
// Sequencer of the chained hash table: hashing, fill fetch, chain walk,
// shifting for insert and delete, and result hand-off.
// ----------------------------------------------------------------------------
module chtab_ctrl
  import chtab_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  chtab_sts_t sts,
  output chtab_ctl_t ctl
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_FRD,
    S_FCAP,
    S_DISP,
    S_INS_RD,
    S_INS_WR,
    S_INS_HEAD,
    S_SC_RD,
    S_SC_CMP,
    S_DEL_RD,
    S_DEL_WR,
    S_DEL_FIN,
    S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [DCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [STATUS_W-1:0] st_r, st_nxt;
  logic [STATUS_W-1:0] miss_status;

  assign miss_status = (sts.cmd == CMD_DELETE) ? ST_DEL_FAIL : ST_NOT_FOUND;

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    st_nxt    = st_r;
    ctl       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        cnt_nxt      = cnt_r + DCNT_W'(1);
        if (cnt_r == DCNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_FRD;
        end
      end
      S_FRD: begin
        ctl.fill_rd = 1'b1;
        state_nxt   = S_FCAP;
      end
      S_FCAP: begin
        ctl.fill_cap = 1'b1;
        state_nxt    = S_DISP;
      end
      S_DISP: begin
        case (sts.cmd)
          CMD_INSERT: begin
            if (sts.fill_full) begin
              st_nxt    = ST_FULL;
              state_nxt = S_DONE;
            end else if (sts.fill_zero) begin
              state_nxt = S_INS_HEAD;
            end else begin
              state_nxt = S_INS_RD;
            end
          end
          CMD_DELETE, CMD_SEARCH: begin
            if (sts.fill_zero) begin
              st_nxt    = miss_status;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_SC_RD;
            end
          end
          default: begin
            st_nxt    = ST_NOT_FOUND;
            state_nxt = S_DONE;
          end
        endcase
      end
      // Insert: move each entry one place back, tail first
      S_INS_RD: begin
        ctl.slot_rd = 1'b1;
        ctl.rd_off  = OFF_DEC;
        state_nxt   = S_INS_WR;
      end
      S_INS_WR: begin
        ctl.slot_wr = 1'b1;
        ctl.idx_op  = IDX_DEC;
        state_nxt   = sts.idx_one ? S_INS_HEAD : S_INS_RD;
      end
      S_INS_HEAD: begin
        ctl.slot_wr  = 1'b1;
        ctl.wr_key   = 1'b1;
        ctl.fill_wr  = 1'b1;
        ctl.fill_inc = 1'b1;
        st_nxt       = ST_INSERTED;
        state_nxt    = S_DONE;
      end
      // Walk the chain from the head for the nearest match
      S_SC_RD: begin
        ctl.slot_rd = 1'b1;
        ctl.rd_off  = OFF_SAME;
        state_nxt   = S_SC_CMP;
      end
      S_SC_CMP: begin
        if (sts.match) begin
          if (sts.cmd == CMD_SEARCH) begin
            st_nxt    = ST_FOUND;
            state_nxt = S_DONE;
          end else begin
            state_nxt = sts.idx_last ? S_DEL_FIN : S_DEL_RD;
          end
        end else if (sts.idx_last) begin
          st_nxt    = miss_status;
          state_nxt = S_DONE;
        end else begin
          ctl.idx_op = IDX_INC;
          state_nxt  = S_SC_RD;
        end
      end
      // Delete: close the gap, moving later entries one place forward
      S_DEL_RD: begin
        ctl.slot_rd = 1'b1;
        ctl.rd_off  = OFF_INC;
        state_nxt   = S_DEL_WR;
      end
      S_DEL_WR: begin
        ctl.slot_wr = 1'b1;
        ctl.idx_op  = IDX_INC;
        state_nxt   = sts.idx_last2 ? S_DEL_FIN : S_DEL_RD;
      end
      S_DEL_FIN: begin
        ctl.fill_wr = 1'b1;
        st_nxt      = ST_DELETED;
        state_nxt   = S_DONE;
      end
      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!sts.out_busy) begin
          ctl.out_load = 1'b1;
          ctl.status   = st_r;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      st_r    <= ST_NOT_FOUND;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      st_r    <= st_nxt;
    end
  end

endmodule

[design/chained_hash_table_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table_unit
// Hash table with separate chaining: key mod bucket count picks a bucket of
// up to sixteen keys; insert at head, delete nearest match, search position.
//
//   channel  dir  transfer carries
//   in_chan  in   command, key
//   out_chan out  status, bucket, position
//   cfg_chan in   data (bucket count)
//
// An item runs a bit-serial remainder over the key and a fill count fetch,
// then walks the visited slots on the single slot RAM read port; the fill
// count is written back after an insert or a delete.
// Reset empties every bucket through per-bucket valid bits, at once; the
// bucket count returns to 64. A stalled result sits in the output register
// while the next command is taken in.
// ----------------------------------------------------------------------------
module chained_hash_table_unit
  import chtab_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  chtab_in_if.sink        in_chan,
  chtab_out_if.source     out_chan,
  chtab_cfg_if.sink       cfg_chan
);

  chtab_ctl_t ctl;
  chtab_sts_t sts;

  // Register writes are always taken
  assign cfg_chan.ready = 1'b1;

  chtab_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  chtab_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_chan.valid),
    .cfg_data     (cfg_chan.data),
    .in_command   (in_chan.command),
    .in_key       (in_chan.key),
    .out_ready    (out_chan.ready),
    .out_valid    (out_chan.valid),
    .out_status   (out_chan.status),
    .out_bucket   (out_chan.bucket),
    .out_position (out_chan.position),
    .ctl          (ctl),
    .sts          (sts)
  );

  // Busy with one command after each input transfer
  a_one_at_a_time : assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("input taken while a command is in progress");

  // Result loads only from the done step, never on top of an unread result
  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> !(out_chan.valid && !out_chan.ready))
    else $error("result register overwritten");

  // Position is only reported with a hit
  a_pos_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.status != ST_FOUND) |-> (out_chan.position == '0))
    else $error("position reported without a hit");

  // Status codes stay within the defined set
  a_status_legal : assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.status <= ST_NOT_FOUND))
    else $error("undefined status code");

endmodule

[verif/chained_hash_table_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table_unit_test
// Self-checking bench for the chained hash table. A queue of table commands
// feeds a clocked driver. Each accepted command runs through a local copy of
// the table, and the expected answer is queued. A clocked monitor compares
// each result field with the oldest expected answer. Both sides idle at
// random. The bucket count is changed between phases while the block is
// drained, and runs through its extremes.
// ----------------------------------------------------------------------------
module chained_hash_table_unit_test;
  import chtab_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam logic [KEY_W-1:0] KEY_TOP     = {KEY_W{1'b1}};
  localparam int PHASES           = 8;
  localparam int ITEMS_PER_PHASE  = 100;
  localparam int LONG_HOLD_AT     = 350;
  localparam int LONG_HOLD_CYCLES = 500;
  localparam int SETTLE_CYCLES    = 100;
  localparam int CYCLE_LIMIT      = 300000;
  localparam int POOL_SIZE        = 40;

  typedef struct {
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key;
    bit               drain_first;
  } table_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BUCKET_W-1:0] bucket;
    logic [POS_W-1:0]    position;
  } table_answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  chtab_in_if  in_if ();
  chtab_out_if out_if ();
  chtab_cfg_if cfg_if ();

  chained_hash_table_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if.sink),
    .out_chan(out_if.source),
    .cfg_chan(cfg_if.sink)
  );

  // Local copy of the table
  logic [KEY_W-1:0]    chain_keys [MAX_BUCKETS][BUCKET_DEPTH];
  int unsigned         chain_fill [MAX_BUCKETS];
  logic [BCOUNT_W-1:0] bucket_count_copy;

  table_op_t     op_queue [$];
  table_answer_t answer_q [$];
  logic [KEY_W-1:0] key_pool [$];

  int unsigned items_planned  = 0;
  int unsigned items_accepted = 0;
  int unsigned results_seen   = 0;
  int unsigned fail_count     = 0;
  int unsigned cycle_count    = 0;
  int unsigned feed_gap       = 0;
  int unsigned hold_left      = 0;

  logic [BCOUNT_W-1:0] phase_counts [PHASES] =
    '{7'd1, 7'd0, 7'd127, 7'd65, 7'd5, 7'd64, 7'd13, 7'd2};

  always #5 clk = ~clk;

  // Number of buckets actually used for a register value
  function automatic int unsigned buckets_for(input logic [BCOUNT_W-1:0] value);
    if (value == '0) return 1;
    if (value > BCOUNT_MAX) return MAX_BUCKETS;
    return value;
  endfunction

  // Apply one command to the local table and return its answer
  function automatic table_answer_t table_apply(input logic [CMD_W-1:0] command,
                                                input logic [KEY_W-1:0] key);
    table_answer_t answer;
    int unsigned   b;
    int unsigned   fill;
    int unsigned   at;
    int unsigned   i;
    b    = key % buckets_for(bucket_count_copy);
    fill = chain_fill[b];
    at   = fill;
    for (i = 0; i < fill; i++)
      if (at == fill && chain_keys[b][i] == key) at = i;
    answer.status   = ST_NOT_FOUND;
    answer.bucket   = BUCKET_W'(b);
    answer.position = '0;
    case (command)
      CMD_INSERT: begin
        if (fill >= BUCKET_DEPTH) begin
          answer.status = ST_FULL;
        end else begin
          for (i = fill; i > 0; i--) chain_keys[b][i] = chain_keys[b][i-1];
          chain_keys[b][0] = key;
          chain_fill[b]    = fill + 1;
          answer.status    = ST_INSERTED;
        end
      end
      CMD_DELETE: begin
        if (at < fill) begin
          for (i = at; i + 1 < fill; i++) chain_keys[b][i] = chain_keys[b][i+1];
          chain_fill[b] = fill - 1;
          answer.status = ST_DELETED;
        end else begin
          answer.status = ST_DEL_FAIL;
        end
      end
      CMD_SEARCH: begin
        if (at < fill) begin
          answer.status   = ST_FOUND;
          answer.position = POS_W'(at);
        end
      end
      default: answer.status = ST_NOT_FOUND;
    endcase
    return answer;
  endfunction

  // Idle draw per transfer, with calm stretches of no idling
  function automatic int unsigned draw_idle(input int unsigned count);
    if ((count / 50) % 3 == 2) return 0;
    return $urandom_range(0, 5);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned seen,
                                 input int unsigned want);
    fail_count++;
    $display("MISMATCH at result %0d: %s got %0d, expected %0d",
             results_seen, what, seen, want);
  endtask

  // Command driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        answer_q.push_back(table_apply(in_if.command, in_if.key));
        items_accepted++;
        feed_gap = draw_idle(items_accepted);
      end
      if (!in_if.valid || in_if.ready) begin
        if (feed_gap > 0) begin
          feed_gap--;
          in_if.valid <= 1'b0;
        end else if (op_queue.size() > 0 &&
                     !(op_queue[0].drain_first && answer_q.size() > 0)) begin
          in_if.valid   <= 1'b1;
          in_if.command <= op_queue[0].command;
          in_if.key     <= op_queue[0].key;
          void'(op_queue.pop_front());
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    table_answer_t want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (answer_q.size() == 0) begin
          report_mismatch("unexpected result, status", out_if.status, 0);
        end else begin
          want = answer_q.pop_front();
          if (out_if.status != want.status)
            report_mismatch("status", out_if.status, want.status);
          if (out_if.bucket != want.bucket)
            report_mismatch("bucket", out_if.bucket, want.bucket);
          if (out_if.position != want.position)
            report_mismatch("position", out_if.position, want.position);
        end
        // hold off once for a long stretch so the block backs up
        hold_left = (results_seen == LONG_HOLD_AT) ? LONG_HOLD_CYCLES
                                                   : draw_idle(results_seen);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  task automatic plan_item(input logic [CMD_W-1:0] command, input logic [KEY_W-1:0] key,
                           input bit drain_first);
    table_op_t op;
    op.command     = command;
    op.key         = key;
    op.drain_first = drain_first;
    op_queue.push_back(op);
    items_planned++;
  endtask

  // Hold until every command is taken and every answer has come back
  task automatic wait_drained();
    while (items_accepted != items_planned || answer_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_bucket_count(input logic [BCOUNT_W-1:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    bucket_count_copy = value;
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly keys that land in a few hot buckets or repeat recent inserts
  function automatic logic [KEY_W-1:0] pick_key(input int unsigned n, input int unsigned hot);
    int unsigned     sel;
    longint unsigned top;
    sel = $urandom_range(0, 99);
    if (sel < 35 && key_pool.size() > 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (sel < 85) begin
      top = (longint'(KEY_TOP) - hot) / n;
      return KEY_W'(longint'($urandom_range(0, int'(top))) * n + hot);
    end
    return KEY_W'($urandom);
  endfunction

  task automatic plan_random_item(input int unsigned n, input int unsigned hot,
                                  input bit drain_first);
    int unsigned      sel;
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key;
    sel = $urandom_range(0, 99);
    if (sel < 45)      command = CMD_INSERT;
    else if (sel < 70) command = CMD_DELETE;
    else if (sel < 95) command = CMD_SEARCH;
    else               command = CMD_UNKNOWN;
    key = pick_key(n, hot);
    if (command == CMD_INSERT) begin
      key_pool.push_back(key);
      if (key_pool.size() > POOL_SIZE) void'(key_pool.pop_front());
    end
    plan_item(command, key, drain_first);
  endtask

  initial begin
    int unsigned n;
    int unsigned hot [3];
    in_if.valid    = 1'b0;
    in_if.command  = CMD_INSERT;
    in_if.key      = '0;
    out_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.data    = '0;
    bucket_count_copy = BCOUNT_RESET;
    foreach (chain_fill[b]) chain_fill[b] = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: fill bucket one to overflow, then middle delete
    for (int i = 0; i <= BUCKET_DEPTH; i++) plan_item(CMD_INSERT, KEY_W'(1 + 64 * i), 1'b0);
    plan_item(CMD_SEARCH, KEY_W'(1), 1'b0);
    plan_item(CMD_DELETE, KEY_W'(1 + 64 * 7), 1'b0);
    // Largest key, duplicate copies, failed delete, unknown command
    plan_item(CMD_INSERT, KEY_TOP, 1'b0);
    plan_item(CMD_INSERT, KEY_TOP, 1'b0);
    plan_item(CMD_DELETE, KEY_TOP, 1'b0);
    plan_item(CMD_SEARCH, KEY_TOP, 1'b0);
    plan_item(CMD_DELETE, KEY_W'(12345), 1'b0);
    plan_item(CMD_INSERT, '0, 1'b0);
    plan_item(CMD_UNKNOWN, KEY_TOP, 1'b0);

    // Random phases, one bucket count each
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_bucket_count(phase_counts[p]);
      n = buckets_for(phase_counts[p]);
      foreach (hot[h]) hot[h] = $urandom_range(0, n - 1);
      for (int k = 0; k < ITEMS_PER_PHASE; k++)
        plan_random_item(n, hot[$urandom_range(0, 2)], p == 3 && k == 50);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (answer_q.size() != 0)
      report_mismatch("answers left outstanding", answer_q.size(), 0);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
